FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the sorted key store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/sks_pkg.sv
// Types and constants shared by the sorted key store modules.
`default_nettype none

package sks_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int KEY_W = 63;
	localparam int POS_W = 10;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CK_STORE,
		CK_ORDER,
		CK_FULL,
		CK_LOOKUP
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PROBE,
		BK_CMP
	} bk_state_t;

	typedef struct packed {
		logic             opcode;
		logic [KEY_W-1:0] key;
	} request_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [1:0]       status;
	} response_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [KEY_W-1:0] key;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_key_store_binary_search_top.sv
// Top level of the sorted key store with binary search lookup.
//
// Channel    Signals                  Handshake
// request    start, busy, request     item taken when start is high and busy is low
// response   done, response           item shown for one cycle while done is high
//
// An append leaves the queue in the idle state and writes the key memory; its result is
// registered and shown. A lookup leaves the queue in the idle state, and each probe of
// the binary search runs the probe state (registered memory read), then the compare
// state, up to ceil(log2(entries + 1)) probes; on a miss a last probe state finds the
// window closed. The result is registered and shown. Reset clears the fill count, last
// key, queue pointers, search state and done flag only. Items wait in the queue while a
// lookup runs; busy rises when the command queue is full; results cannot be stalled.
`default_nettype none

module sorted_key_store_binary_search_top #(
	parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF,
	parameter int QUEUE_DEPTH = sks_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sks_pkg::request_t request,
	output logic                   busy,
	output logic                   done,
	output sks_pkg::response_t     response
);

	import sks_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int QW = $bits(cmd_t) + CW;

	logic          push;
	cmd_t          push_cmd;
	logic [CW-1:0] push_idx;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	logic [QW-1:0] head_data;
	cmd_t          head_cmd;
	logic [CW-1:0] head_idx;

	assign head_cmd = cmd_t'(head_data[QW-1:CW]);
	assign head_idx = head_data[CW-1:0];

	sks_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.q_full   (q_full),
		.busy     (busy),
		.push     (push),
		.push_cmd (push_cmd),
		.push_idx (push_idx)
	);

	sks_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_idx}),
		.pop       (pop),
		.pop_data  (head_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	sks_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head_cmd (head_cmd),
		.head_idx (head_idx),
		.pop      (pop),
		.done     (done),
		.response (response)
	);

endmodule

`default_nettype wire

FILE: rtl/sks_queue.sv
// Small command queue between the front and the back of the key store.
`default_nettype none
`include "assert_macros.svh"

module sks_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;

	assign full     = (cnt_q == NW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_queue_overrun, clk, arst_n, push && full && !pop, "queue written while full")

endmodule

`default_nettype wire

FILE: rtl/sks_front.sv
// Front end: accepts items, tracks fill state and classifies each append.
`default_nettype none
`include "assert_macros.svh"

module sks_front #(
	parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sks_pkg::request_t request,
	input  wire logic              q_full,
	output logic                   busy,
	output logic                   push,
	output sks_pkg::cmd_t          push_cmd,
	output logic [CW-1:0]          push_idx
);

	import sks_pkg::*;

	logic [CW-1:0]    count_q;
	logic [KEY_W-1:0] last_q;
	logic             table_full;

	assign busy       = q_full;
	assign push       = start && !q_full;
	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign push_idx   = count_q;

	always_comb begin
		push_cmd.key = request.key;
		if (request.opcode == OP_LOOKUP) begin
			push_cmd.kind = CK_LOOKUP;
		end else if (table_full) begin
			push_cmd.kind = CK_FULL;
		end else if (count_q != '0 && request.key <= last_q) begin
			push_cmd.kind = CK_ORDER;
		end else begin
			push_cmd.kind = CK_STORE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
		end else if (push && push_cmd.kind == CK_STORE) begin
			count_q <= count_q + 1'b1;
			last_q  <= request.key;
		end
	end

	`ASSERT_PROP(a_count_bound, clk, arst_n, count_q <= CW'(TABLE_DEPTH), "entry count past depth")

endmodule

`default_nettype wire

FILE: rtl/sks_back.sv
// Back end: key memory, append writes and the binary search sequencer.
`default_nettype none
`include "assert_macros.svh"

module sks_back #(
	parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire sks_pkg::cmd_t  head_cmd,
	input  wire logic [CW-1:0]  head_idx,
	output logic                pop,
	output logic                done,
	output sks_pkg::response_t  response
);

	import sks_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	logic [KEY_W-1:0] mem [TABLE_DEPTH];

	bk_state_t        state_q;
	bk_state_t        state_d;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [IW-1:0]    mid_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] rd_q;
	logic             done_q;
	response_t        resp_q;

	logic [CW-1:0]    mid_wide;
	logic [IW-1:0]    mid;
	logic             window_open;
	logic             hit;
	logic             mem_we;
	logic             emit;
	response_t        emit_resp;

	assign mid_wide    = lo_q + ((hi_q - lo_q) >> 1);
	assign mid         = mid_wide[IW-1:0];
	assign window_open = (lo_q < hi_q);
	assign hit         = (rd_q == key_q);
	assign done        = done_q;
	assign response    = resp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && head_cmd.kind == CK_LOOKUP) begin
					state_d = BK_PROBE;
				end
			end
			BK_PROBE: begin
				state_d = window_open ? BK_CMP : BK_IDLE;
			end
			BK_CMP: begin
				state_d = hit ? BK_IDLE : BK_PROBE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		emit      = 1'b0;
		emit_resp = '{found: 1'b0, position: '0, status: ST_OK};
		case (state_q)
			BK_IDLE: begin
				pop = !q_empty;
				if (!q_empty) begin
					case (head_cmd.kind)
						CK_STORE: begin
							mem_we             = 1'b1;
							emit               = 1'b1;
							emit_resp.found    = 1'b1;
							emit_resp.position = POS_W'(head_idx);
						end
						CK_ORDER: begin
							emit             = 1'b1;
							emit_resp.status = ST_ORDER;
						end
						CK_FULL: begin
							emit             = 1'b1;
							emit_resp.status = ST_FULL;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			BK_PROBE: begin
				emit = !window_open;
			end
			BK_CMP: begin
				if (hit) begin
					emit               = 1'b1;
					emit_resp.found    = 1'b1;
					emit_resp.position = POS_W'(mid_q);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head_idx[IW-1:0]] <= head_cmd.key;
		end
		rd_q <= mem[mid];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				lo_q  <= '0;
				hi_q  <= head_idx;
				key_q <= head_cmd.key;
			end
			BK_PROBE: begin
				mid_q <= mid;
			end
			BK_CMP: begin
				if (rd_q > key_q) begin
					hi_q <= CW'(mid_q);
				end else begin
					lo_q <= CW'(mid_q) + 1'b1;
				end
			end
			default: begin
				mid_q <= mid_q;
			end
		endcase
		if (emit) begin
			resp_q <= emit_resp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	`ASSERT_PROP(a_found_ok, clk, arst_n, done_q && resp_q.found |-> resp_q.status == ST_OK, "found result with error status")
	`ASSERT_PROP(a_cmp_after_probe, clk, arst_n, state_q == BK_CMP |-> $past(state_q) == BK_PROBE, "compare without a probe")
	`ASSERT_NEVER(a_pop_busy, clk, arst_n, pop && state_q != BK_IDLE, "queue popped during a search")

endmodule

`default_nettype wire
